>>> sv/pkcnt_pkg.sv
// ----------------------------------------------------------------------------
// pkcnt_pkg
// Types and constants shared by the per-key byte counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package pkcnt_pkg;

    localparam int KEY_BITS   = 22;
    localparam int COUNT_BITS = 32;
    localparam int TOTAL_BITS = 64;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_IGNORED  = 2'd2,
        ST_DROPPED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_READ,
        CTL_PROBE,
        CTL_UPDATE
    } ctl_state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]          key;
        logic signed [COUNT_BITS-1:0] byte_count;
        logic                         direction;
    } in_t;

    typedef struct packed {
        status_t                 status;
        logic [TOTAL_BITS-1:0]   rx_total;
        logic [TOTAL_BITS-1:0]   tx_total;
    } out_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [TOTAL_BITS-1:0] rx;
        logic [TOTAL_BITS-1:0] tx;
    } entry_t;

endpackage

`default_nettype wire

>>> sv/pkcnt_store.sv
// ----------------------------------------------------------------------------
// pkcnt_store
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pkcnt_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire pkcnt_pkg::entry_t     wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output pkcnt_pkg::entry_t          rd_data
);
    import pkcnt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/pkcnt_ctrl.sv
// ----------------------------------------------------------------------------
// pkcnt_ctrl
// Hashed linear-probe sequencer: clears the table, probes, then updates.
// ----------------------------------------------------------------------------
`default_nettype none

module pkcnt_ctrl #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pkcnt_pkg::in_t        s_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output pkcnt_pkg::out_t            res_data,
    output logic                       rd_en,
    output logic [IDX_W-1:0]           rd_addr,
    input  wire pkcnt_pkg::entry_t     rd_data,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_addr,
    output pkcnt_pkg::entry_t          wr_data
);
    import pkcnt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W:0]   NUM_ENT  = (IDX_W + 1)'(TABLE_ENTRIES);

    // Fold the key onto the index width, then bring it below the table size.
    function automatic logic [IDX_W-1:0] hash_idx(input logic [KEY_BITS-1:0] key_in);
        logic [IDX_W-1:0] fold;
        logic [IDX_W:0]   wide;
        fold = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            fold[i % IDX_W] = fold[i % IDX_W] ^ key_in[i];
        end
        wide = {1'b0, fold};
        if (wide >= NUM_ENT) begin
            wide = wide - NUM_ENT;
        end
        return wide[IDX_W-1:0];
    endfunction

    ctl_state_t        state_reg,  state_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [IDX_W-1:0]  probes_reg, probes_next;
    in_t               item_reg,   item_next;
    entry_t            entry_reg,  entry_next;
    logic              hit_reg,    hit_next;
    logic              empty_reg,  empty_next;

    logic [IDX_W-1:0]      idx_inc;
    logic                  match;
    logic                  empty;
    logic                  last_probe;
    logic                  positive;
    logic                  do_write;
    logic [TOTAL_BITS-1:0] cnt_ext;
    logic [TOTAL_BITS-1:0] base_rx;
    logic [TOTAL_BITS-1:0] base_tx;
    logic [TOTAL_BITS-1:0] new_rx;
    logic [TOTAL_BITS-1:0] new_tx;
    entry_t                upd_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= CTL_CLEAR;
            idx_reg    <= '0;
            probes_reg <= '0;
            hit_reg    <= 1'b0;
            empty_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            probes_reg <= probes_next;
            hit_reg    <= hit_next;
            empty_reg  <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        entry_reg <= entry_next;
    end

    assign idx_inc    = (idx_reg == LAST_IDX) ? '0 : IDX_W'(idx_reg + 1'b1);
    assign match      = rd_data.valid && (rd_data.key == item_reg.key);
    assign empty      = !rd_data.valid;
    assign last_probe = (probes_reg == LAST_IDX);

    // Result and write-back data for the entry chosen by the probe.
    always_comb begin
        positive = (item_reg.byte_count > 32'sd0);
        do_write = positive && (hit_reg || empty_reg);
        cnt_ext  = {{(TOTAL_BITS - COUNT_BITS){1'b0}}, item_reg.byte_count};
        base_rx  = hit_reg ? entry_reg.rx : '0;
        base_tx  = hit_reg ? entry_reg.tx : '0;
        new_rx   = base_rx;
        new_tx   = base_tx;
        if (do_write) begin
            if (item_reg.direction) begin
                new_tx = base_tx + cnt_ext;
            end else begin
                new_rx = base_rx + cnt_ext;
            end
        end
        priority if (!positive) begin
            res_data.status = ST_IGNORED;
        end else if (hit_reg) begin
            res_data.status = ST_UPDATED;
        end else if (empty_reg) begin
            res_data.status = ST_INSERTED;
        end else begin
            res_data.status = ST_DROPPED;
        end
        res_data.rx_total = new_rx;
        res_data.tx_total = new_tx;
        upd_entry.valid   = 1'b1;
        upd_entry.key     = item_reg.key;
        upd_entry.rx      = new_rx;
        upd_entry.tx      = new_tx;
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        probes_next = probes_reg;
        item_next   = item_reg;
        entry_next  = entry_reg;
        hit_next    = hit_reg;
        empty_next  = empty_reg;
        s_ready     = 1'b0;
        res_valid   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '0;
        unique case (state_reg)
            CTL_CLEAR: begin
                // sweep every entry to invalid after reset
                wr_en = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = CTL_IDLE;
                end else begin
                    idx_next = idx_inc;
                end
            end
            CTL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next   = s_data;
                    idx_next    = hash_idx(s_data.key);
                    probes_next = '0;
                    state_next  = CTL_READ;
                end
            end
            CTL_READ: begin
                rd_en      = 1'b1;
                state_next = CTL_PROBE;
            end
            CTL_PROBE: begin
                if (match || empty || last_probe) begin
                    entry_next = rd_data;
                    hit_next   = match;
                    empty_next = empty && !match;
                    state_next = CTL_UPDATE;
                end else begin
                    // advance to the next slot and keep reading
                    rd_en       = 1'b1;
                    rd_addr     = idx_inc;
                    idx_next    = idx_inc;
                    probes_next = IDX_W'(probes_reg + 1'b1);
                end
            end
            CTL_UPDATE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    wr_en      = do_write;
                    wr_data    = upd_entry;
                    state_next = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == CTL_CLEAR || state_reg == CTL_UPDATE))
        else $error("table written outside clear or update");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == CTL_READ))
        else $error("accepted transfer did not start a lookup");

    a_ignored_status: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> ((res_data.status == ST_IGNORED) == !positive))
        else $error("ignored status does not follow byte count sign");

    a_dropped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_data.status == ST_DROPPED)
            |-> (res_data.rx_total == '0 && res_data.tx_total == '0))
        else $error("dropped result carries nonzero totals");

    a_update_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && state_reg == CTL_UPDATE)
            |-> (wr_data.valid && wr_data.key == item_reg.key))
        else $error("update wrote an entry for the wrong key");

endmodule

`default_nettype wire

>>> sv/per_key_byte_counter_table_core.sv
// Sequence: an accepted input passes through the READ, PROBE and UPDATE states
//   of the controller; PROBE moves on slot by slot until it finds the key, a
//   free slot, or has probed every slot, and the result is then registered.
// Items: s_ready is high only while idle, so no new item is taken before the
//   last result is handed on; a low m_ready can hold the controller in UPDATE.
// Reset: synchronous, active low; a pass then clears every entry, s_ready low.
// ----------------------------------------------------------------------------
// per_key_byte_counter_table_core
// Per-key receive/transmit byte totals held in a hashed, linearly probed table.
// ----------------------------------------------------------------------------
`default_nettype none

module per_key_byte_counter_table_core #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire pkcnt_pkg::in_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output pkcnt_pkg::out_t      m_data
);
    import pkcnt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic              res_valid;
    logic              res_ready;
    out_t              res_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg,  m_data_next;

    pkcnt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    pkcnt_store #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: take a new result when empty or while the held one is being transferred.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
